FILE: hdl/u8sd_pkg.sv
// ----------------------------------------------------------------------------
// u8sd_pkg
// Types, constants and lead byte helpers for the UTF-8 stream decoder.
// ----------------------------------------------------------------------------
package u8sd_pkg;

  localparam int unsigned CpWidth  = 31;
  localparam int unsigned LenWidth = 3;

  localparam logic [7:0] LeadMask2   = 8'hE0;
  localparam logic [7:0] LeadMask3   = 8'hF0;
  localparam logic [7:0] LeadMask4   = 8'hF8;
  localparam logic [7:0] LeadMask5   = 8'hFC;
  localparam logic [7:0] LeadMask6   = 8'hFE;
  localparam logic [7:0] ContMask    = 8'hC0;
  localparam logic [7:0] ContMark    = 8'h80;
  localparam logic [7:0] Overlong2   = 8'h1E;
  localparam logic [7:0] LowSeven    = 8'h7F;
  localparam logic [7:0] LowSix      = 8'h3F;
  localparam logic [CpWidth-1:0] BmpMax = 31'h0000_FFFF;

  typedef logic [LenWidth-1:0] len_t;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       last_byte;
  } byte_item_t;

  typedef struct packed {
    logic [CpWidth-1:0] code_point;
    logic               has_code_point;
    logic               end_of_string;
    logic               string_failed;
  } cp_item_t;

  // Sequence length from a lead byte; zero marks an invalid lead.
  function automatic len_t lead_length(input logic [7:0] b);
    len_t len;
    if (!b[7]) begin
      len = 3'd1;
    end else if ((b & LeadMask2) == 8'hC0) begin
      len = 3'd2;
    end else if ((b & LeadMask3) == 8'hE0) begin
      len = 3'd3;
    end else if ((b & LeadMask4) == 8'hF0) begin
      len = 3'd4;
    end else if ((b & LeadMask5) == 8'hF8) begin
      len = 3'd5;
    end else if ((b & LeadMask6) == 8'hFC) begin
      len = 3'd6;
    end else begin
      len = 3'd0;
    end
    return len;
  endfunction

  // Payload bits carried by a lead byte of the given length.
  function automatic logic [7:0] lead_payload_mask(input len_t len);
    logic [7:0] m;
    case (len)
      3'd2: begin
        m = 8'h1F;
      end
      3'd3: begin
        m = 8'h0F;
      end
      3'd4: begin
        m = 8'h07;
      end
      3'd5: begin
        m = 8'h03;
      end
      3'd6: begin
        m = 8'h01;
      end
      default: begin
        m = 8'h00;
      end
    endcase
    return m;
  endfunction

endpackage

FILE: hdl/utf8_stream_decoder_unit.sv
// ----------------------------------------------------------------------------
// utf8_stream_decoder_unit
// Decodes a UTF-8 byte stream (legacy 1 to 6 byte forms) into code points.
// ----------------------------------------------------------------------------
// While byte_stall is low, one byte is taken per clock and throughput is one
// item per clock: an input register feeds the combinational decode logic,
// whose answer lands in a result register. A result reaches cp through the
// input and result registers. When a result waits under cp_stall, byte_stall
// rises once the input register holds a byte that also has a result to
// deliver. The sequence state (remaining count, length, position, partial
// value, failed flag) is updated in the same cycle the byte leaves the input
// register, so the next byte of a sequence can follow immediately. Bytes that
// complete no code point and do not end a string produce no result. On the
// final byte of a string exactly one result appears, with string_failed set
// if anything in the string was invalid; the consumer then discards that
// string's code points. The user must write the drop_above_bmp register
// through cfg only while idle; the block does not enforce this.
module utf8_stream_decoder_unit (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  byte_valid,
  output logic                  byte_stall,
  input  u8sd_pkg::byte_item_t  byte_item,
  output logic                  cp_valid,
  input  logic                  cp_stall,
  output u8sd_pkg::cp_item_t    cp_item,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic                  cfg_data
);

  localparam int unsigned W = u8sd_pkg::CpWidth;

  logic                  drop_above_bmp;
  logic                  s1_valid;
  u8sd_pkg::byte_item_t  s1_item;

  u8sd_pkg::len_t        bytes_remaining, bytes_remaining_next;
  u8sd_pkg::len_t        sequence_length, sequence_length_next;
  u8sd_pkg::len_t        byte_position, byte_position_next;
  logic [W-1:0]          partial_value, partial_value_next;
  logic                  failed_flag, failed_flag_next;

  u8sd_pkg::cp_item_t    result;
  logic                  has_result;
  logic                  out_free;
  logic                  s1_move;

  assign cfg_ready  = 1'b1;
  assign out_free   = !cp_valid || !cp_stall;
  assign s1_move    = s1_valid && (!has_result || out_free);
  assign byte_stall = s1_valid && !s1_move;

  always_comb begin
    logic [7:0]      b;
    u8sd_pkg::len_t  len;
    u8sd_pkg::len_t  sh;
    logic [W-1:0]    acc;
    logic [W-1:0]    cp;
    logic            have;
    logic            fail;

    b   = s1_item.byte_in;
    len = u8sd_pkg::lead_length(b);
    sh  = ((sequence_length >= 3'd3) && (sequence_length <= 3'd6))
          ? 3'd7 - sequence_length : 3'd1;
    acc = {partial_value[W-7:0], b[5:0]};
    cp   = '0;
    have = 1'b0;
    fail = 1'b0;

    bytes_remaining_next = bytes_remaining;
    sequence_length_next = sequence_length;
    byte_position_next   = byte_position;
    partial_value_next   = partial_value;
    failed_flag_next     = failed_flag;

    if (!failed_flag) begin
      if (bytes_remaining == 3'd0) begin
        if (len == 3'd0) begin
          fail = 1'b1;
        end else if (len == 3'd1) begin
          cp   = W'(b);
          have = 1'b1;
        end else if (len == 3'd2 && (b & u8sd_pkg::Overlong2) == 8'h00) begin
          fail = 1'b1;
        end else begin
          partial_value_next   = W'(b & u8sd_pkg::lead_payload_mask(len));
          sequence_length_next = len;
          byte_position_next   = 3'd1;
          bytes_remaining_next = len - 3'd1;
        end
      end else begin
        if ((b & u8sd_pkg::ContMask) != u8sd_pkg::ContMark) begin
          fail = 1'b1;
        end else if (byte_position == 3'd2 && partial_value == '0 &&
                     ((b & u8sd_pkg::LowSeven) >> sh) == 8'h00) begin
          // overlong check at the third byte
          fail = 1'b1;
        end else begin
          partial_value_next   = acc;
          byte_position_next   = byte_position + 3'd1;
          bytes_remaining_next = bytes_remaining - 3'd1;
          if (bytes_remaining == 3'd1) begin
            cp   = acc;
            have = 1'b1;
            bytes_remaining_next = '0;
            sequence_length_next = '0;
            byte_position_next   = '0;
            partial_value_next   = '0;
          end
        end
      end
    end

    if (fail) begin
      failed_flag_next     = 1'b1;
      bytes_remaining_next = '0;
      sequence_length_next = '0;
      byte_position_next   = '0;
      partial_value_next   = '0;
    end

    if (have && drop_above_bmp && cp > u8sd_pkg::BmpMax) begin
      have = 1'b0;
      cp   = '0;
    end

    result.code_point     = cp;
    result.has_code_point = have;
    result.end_of_string  = 1'b0;
    result.string_failed  = 1'b0;

    if (s1_item.last_byte) begin
      if (bytes_remaining_next != 3'd0 || failed_flag_next) begin
        result.code_point     = '0;
        result.has_code_point = 1'b0;
        result.string_failed  = 1'b1;
      end
      result.end_of_string = 1'b1;
      failed_flag_next     = 1'b0;
      bytes_remaining_next = '0;
      sequence_length_next = '0;
      byte_position_next   = '0;
      partial_value_next   = '0;
    end

    has_result = have || s1_item.last_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      drop_above_bmp  <= 1'b0;
      s1_valid        <= 1'b0;
      cp_valid        <= 1'b0;
      bytes_remaining <= '0;
      sequence_length <= '0;
      byte_position   <= '0;
      partial_value   <= '0;
      failed_flag     <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        drop_above_bmp <= cfg_data;
      end

      if (byte_valid && !byte_stall) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end

      if (s1_move && has_result) begin
        cp_valid <= 1'b1;
      end else if (!cp_stall) begin
        cp_valid <= 1'b0;
      end

      if (s1_move) begin
        bytes_remaining <= bytes_remaining_next;
        sequence_length <= sequence_length_next;
        byte_position   <= byte_position_next;
        partial_value   <= partial_value_next;
        failed_flag     <= failed_flag_next;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (byte_valid && !byte_stall) begin
      s1_item <= byte_item;
    end
    if (s1_move && has_result) begin
      cp_item <= result;
    end
  end

endmodule

FILE: hdl/u8sd_checker.sv
// ----------------------------------------------------------------------------
// u8sd_checker
// Port-level checks for the UTF-8 stream decoder, bound to the top level.
// ----------------------------------------------------------------------------
module u8sd_checker (
  input logic                  clk,
  input logic                  rst,
  input logic                  byte_valid,
  input logic                  byte_stall,
  input u8sd_pkg::byte_item_t  byte_item,
  input logic                  cp_valid,
  input logic                  cp_stall,
  input u8sd_pkg::cp_item_t    cp_item,
  input logic                  cfg_valid,
  input logic                  cfg_ready,
  input logic                  cfg_data
);

  // a stalled result item holds
  assert property (@(posedge clk) disable iff (rst)
    cp_valid && cp_stall |=> cp_valid && $stable(cp_item))
    else $error("result item changed while stalled");

  // nothing left over after reset
  assert property (@(posedge clk) rst |=> !cp_valid)
    else $error("result valid right after reset");

  // a failed string ends with an empty result
  assert property (@(posedge clk) disable iff (rst)
    cp_valid && cp_item.string_failed |->
      cp_item.end_of_string && !cp_item.has_code_point && cp_item.code_point == '0)
    else $error("failed result is not a bare end item");

  // mid-string results always carry a character
  assert property (@(posedge clk) disable iff (rst)
    cp_valid && !cp_item.end_of_string |-> cp_item.has_code_point)
    else $error("empty result before end of string");

  // an empty result carries code point zero
  assert property (@(posedge clk) disable iff (rst)
    cp_valid && !cp_item.has_code_point |-> cp_item.code_point == '0)
    else $error("code point set without a character");

endmodule

bind utf8_stream_decoder_unit u8sd_checker u8sd_checker_i (.*);

FILE: verif/utf8_stream_decoder_unit_test.sv
// ----------------------------------------------------------------------------
// utf8_stream_decoder_unit_test
// Self-checking bench for the UTF-8 stream decoder. Bytes go in as strings
// with random pacing and output stalls. A local decoder model predicts every
// code point and end-of-string result, and each result is checked in order.
// ----------------------------------------------------------------------------
module utf8_stream_decoder_unit_test;

  localparam int CpWidth       = u8sd_pkg::CpWidth;
  localparam int WatchdogLimit = 3000;
  localparam int SettleCycles  = 4;
  localparam int RandomItems   = 1250;
  localparam int RandomPhases  = 6;
  localparam int MaxPrinted    = 40;

  logic                 clk;
  logic                 rst;
  logic                 byte_valid;
  logic                 byte_stall;
  u8sd_pkg::byte_item_t byte_item;
  logic                 cp_valid;
  logic                 cp_stall;
  u8sd_pkg::cp_item_t   cp_item;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic                 cfg_data;

  utf8_stream_decoder_unit u_top (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_item  (byte_item),
    .cp_valid   (cp_valid),
    .cp_stall   (cp_stall),
    .cp_item    (cp_item),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  // Decoder model state
  logic [2:0]         seq_left;
  logic [2:0]         seq_len;
  logic [2:0]         seq_pos;
  logic [CpWidth-1:0] seq_acc;
  logic               str_failed;
  logic               drop_bmp;

  u8sd_pkg::cp_item_t pending_cps[$];
  logic [7:0]         enc_bytes[$];
  int                 mismatches;
  int                 idle_cycles;
  int                 burst_left;
  bit                 no_gaps;
  int                 hold_left;
  int                 rx_cycle;
  int                 random_items;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic void clear_sequence();
    seq_left = '0;
    seq_len  = '0;
    seq_pos  = '0;
    seq_acc  = '0;
  endfunction

  function automatic void abandon_string();
    str_failed = 1'b1;
    clear_sequence();
  endfunction

  // Advances the model by one byte; returns 1 when a result is due.
  function automatic bit decode_byte(input u8sd_pkg::byte_item_t it,
                                     output u8sd_pkg::cp_item_t res);
    logic [7:0]         b;
    int                 len;
    int                 sh;
    logic [CpWidth-1:0] cp;
    bit                 have;
    b    = it.byte_in;
    cp   = '0;
    have = 1'b0;
    if (!str_failed) begin
      if (seq_left == 0) begin
        casez (b)
          8'b0???????: len = 1;
          8'b110?????: len = 2;
          8'b1110????: len = 3;
          8'b11110???: len = 4;
          8'b111110??: len = 5;
          8'b1111110?: len = 6;
          default:     len = 0;
        endcase
        if (len == 0) begin
          abandon_string();
        end else if (len == 1) begin
          cp   = CpWidth'(b);
          have = 1'b1;
        end else if (len == 2 && b[4:1] == 4'b0) begin
          abandon_string();
        end else begin
          seq_acc  = CpWidth'(b & (8'hFF >> (len + 1)));
          seq_len  = 3'(len);
          seq_pos  = 3'd1;
          seq_left = 3'(len - 1);
        end
      end else begin
        sh = (seq_len >= 3 && seq_len <= 6) ? 7 - seq_len : 1;
        if (b[7:6] != 2'b10) begin
          abandon_string();
        end else if (seq_pos == 3'd2 && seq_acc == '0 && ((b & 8'h7F) >> sh) == 0) begin
          // overlong form caught at the third byte
          abandon_string();
        end else begin
          seq_acc  = {seq_acc[CpWidth-7:0], b[5:0]};
          seq_pos  = seq_pos + 3'd1;
          seq_left = seq_left - 3'd1;
          if (seq_left == 0) begin
            cp   = seq_acc;
            have = 1'b1;
            clear_sequence();
          end
        end
      end
    end
    if (have && drop_bmp && cp > CpWidth'(32'hFFFF)) begin
      have = 1'b0;
      cp   = '0;
    end
    if (it.last_byte) begin
      if (seq_left != 0) str_failed = 1'b1;
      if (str_failed) begin
        have = 1'b0;
        cp   = '0;
      end
      res = '{code_point: cp, has_code_point: have, end_of_string: 1'b1,
              string_failed: str_failed};
      str_failed = 1'b0;
      clear_sequence();
      return 1'b1;
    end
    res = '{code_point: cp, has_code_point: 1'b1, end_of_string: 1'b0,
            string_failed: 1'b0};
    return have;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatches < MaxPrinted) begin
      $display("MISMATCH %s: got 0x%0h, expected 0x%0h", what, got, want);
    end
    mismatches++;
  endtask

  // Predicts on accepted bytes, then checks the outgoing result.
  always @(posedge clk) begin : scoreboard
    u8sd_pkg::cp_item_t res;
    u8sd_pkg::cp_item_t want;
    if (!rst) begin
      if (cfg_valid && cfg_ready) drop_bmp = cfg_data;
      if (byte_valid && !byte_stall) begin
        if (decode_byte(byte_item, res)) pending_cps.push_back(res);
      end
      if (cp_valid && !cp_stall) begin
        if (pending_cps.size() == 0) begin
          report_mismatch("unexpected result", {1'b0, cp_item.code_point}, 32'h0);
        end else begin
          want = pending_cps.pop_front();
          if (cp_item.code_point !== want.code_point)
            report_mismatch("code_point", {1'b0, cp_item.code_point},
                            {1'b0, want.code_point});
          if (cp_item.has_code_point !== want.has_code_point)
            report_mismatch("has_code_point", 32'(cp_item.has_code_point),
                            32'(want.has_code_point));
          if (cp_item.end_of_string !== want.end_of_string)
            report_mismatch("end_of_string", 32'(cp_item.end_of_string),
                            32'(want.end_of_string));
          if (cp_item.string_failed !== want.string_failed)
            report_mismatch("string_failed", 32'(cp_item.string_failed),
                            32'(want.string_failed));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (byte_valid && !byte_stall) || (cp_valid && !cp_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Output stall: a forced hold-off when requested, else rotating patterns
  always @(negedge clk) begin
    if (rst) begin
      cp_stall <= 1'b0;
    end else if (hold_left > 0) begin
      cp_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      rx_cycle = rx_cycle + 1;
      case ((rx_cycle / 64) % 4)
        0: begin
          cp_stall <= 1'b0;
        end
        1: begin
          cp_stall <= ($urandom_range(0, 3) == 0);
        end
        2: begin
          cp_stall <= ($urandom_range(0, 3) != 0);
        end
        default: begin
          cp_stall <= (rx_cycle % 3 == 0);
        end
      endcase
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    if (!no_gaps && burst_left == 0) begin
      gap = $urandom_range(0, 5);
      if (gap > 0) begin
        @(negedge clk);
        byte_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    if (burst_left > 0) burst_left--;
    @(negedge clk);
    byte_valid <= 1'b1;
    byte_item  <= '{byte_in: b, last_byte: last};
    @(posedge clk);
    while (byte_stall) @(posedge clk);
  endtask

  // Stops offering bytes and waits until every expected result is out.
  task automatic settle();
    @(negedge clk);
    byte_valid <= 1'b0;
    burst_left = 0;
    while (pending_cps.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_drop(input logic value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_directed_sequences();
    send_byte(8'h00, 1'b0);  // zero byte is a normal code point
    send_byte(8'h7F, 1'b1);
    send_byte(8'hC0, 1'b0);  // overlong two-byte lead, rest ignored
    send_byte(8'h80, 1'b1);
    send_byte(8'hE0, 1'b0);  // overlong caught at third byte
    send_byte(8'h80, 1'b0);
    send_byte(8'h80, 1'b1);
    send_byte(8'hFD, 1'b0);  // six-byte form, largest value
    repeat (4) send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b1);
    send_byte(8'hFE, 1'b1);  // invalid lead
    send_byte(8'h80, 1'b1);  // stray continuation
    send_byte(8'hF0, 1'b0);  // string ends inside a sequence
    send_byte(8'h90, 1'b1);
    send_byte(8'hC2, 1'b0);  // bad continuation
    send_byte(8'h41, 1'b1);
    settle();
  endtask

  task automatic test_bmp_drop();
    write_drop(1'b1);
    send_byte(8'hEF, 1'b0);  // U+FFFF stays
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hF4, 1'b0);  // dropped on the string's last byte
    send_byte(8'h8F, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b1);
    settle();
  endtask

  task automatic send_random_string();
    int         n_chars;
    int         kind;
    int         len;
    logic [7:0] b;
    enc_bytes.delete();
    n_chars = $urandom_range(1, 10);
    repeat (n_chars) begin
      kind = $urandom_range(0, 99);
      len  = (kind < 80) ? $urandom_range(1, 6) : $urandom_range(2, 6);
      if (kind >= 80 && kind < 84) begin
        enc_bytes.push_back(8'($urandom_range(0, 255)));
      end else if (kind >= 84 && kind < 88) begin
        // zero payload: overlong at the lead or at the third byte
        enc_bytes.push_back(8'(8'hFF << (8 - len)));
        repeat (len - 1) enc_bytes.push_back(8'h80);
      end else begin
        if (len == 1) begin
          b = 8'($urandom_range(0, 127));
        end else begin
          b = 8'(8'hFF << (8 - len)) | (8'($urandom) & (8'hFF >> (len + 1)));
        end
        enc_bytes.push_back(b);
        repeat (len - 1) enc_bytes.push_back({2'b10, 6'($urandom)});
        if (kind >= 94) begin
          b = enc_bytes.pop_back();
          b[7:6] = 2'($urandom_range(0, 2));
          if (b[7:6] == 2'b10) b[7:6] = 2'b11;
          enc_bytes.push_back(b);
        end else if (kind >= 88) begin
          void'(enc_bytes.pop_back());
        end
      end
    end
    foreach (enc_bytes[i]) send_byte(enc_bytes[i], i == enc_bytes.size() - 1);
    random_items += enc_bytes.size();
  endtask

  task automatic test_random_strings();
    for (int phase = 0; phase < RandomPhases; phase++) begin
      write_drop(phase[0]);
      while (random_items < (phase + 1) * RandomItems / RandomPhases) begin
        send_random_string();
      end
      settle();
    end
  endtask

  // Receiver holds off while bytes keep coming, so the input backs up.
  task automatic test_receiver_holdoff();
    hold_left = 120;
    no_gaps   = 1'b1;
    for (int i = 0; i < 48; i++) begin
      send_byte(8'(8'h41 + i % 26), (i % 6) == 5);
    end
    no_gaps = 1'b0;
    settle();
  endtask

  initial begin
    rst          = 1'b1;
    byte_valid   = 1'b0;
    byte_item    = '0;
    cfg_valid    = 1'b0;
    cfg_data     = 1'b0;
    cp_stall     = 1'b0;
    mismatches   = 0;
    idle_cycles  = 0;
    burst_left   = 0;
    no_gaps      = 1'b0;
    hold_left    = 0;
    rx_cycle     = 0;
    random_items = 0;
    drop_bmp     = 1'b0;
    str_failed   = 1'b0;
    clear_sequence();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_sequences();
    test_bmp_drop();
    test_random_strings();
    test_receiver_holdoff();

    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: utf8_stream_decoder_unit.f
hdl/u8sd_pkg.sv
hdl/utf8_stream_decoder_unit.sv
hdl/u8sd_checker.sv
verif/utf8_stream_decoder_unit_test.sv
